// ----- rtl/ifla_pkg.sv -----
// Shared types and constants for the index free-list allocator.
// No dependencies; imported by the allocator and its checker.
package ifla_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int RESERVED_ENTRIES  = 2;

  localparam int IDX_FIELD_W = 10;
  localparam int CNT_FIELD_W = 11;
  localparam int STAT_W      = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

// ----- rtl/ifla_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Holds the per-entry {busy, next link} words of the allocator. No dependencies.
module ifla_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 11
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/index_free_list_allocator.sv -----
// Index free-list allocator: LIFO free list of links plus busy flags in one RAM.
// Result: RAM read at accept, then applied in S_EXEC and registered once the output slot is free.
// One item at a time: in_stall is high in S_EXEC, as the RAM read of the head's link or the
// released entry's word must land before the item can be applied.
// Reset (rst_n low, synchronous) clears control state; the RAM is not swept, a
// fresh pointer stands in for untouched entries, so the block is ready at once.
module index_free_list_allocator
  import ifla_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [IDX_FIELD_W-1:0] in_release_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [IDX_FIELD_W-1:0] out_granted_index,
  output logic [STAT_W-1:0]      out_status,
  output logic [CNT_FIELD_W-1:0] out_free_total,
  output logic [CNT_FIELD_W-1:0] out_busy_total
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = IW + 1;

  localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_ENTRIES - 1);
  localparam logic [IW-1:0] HEAD_INIT = IW'(RESERVED_ENTRIES);
  localparam logic [CW-1:0] RSV_CNT   = CW'(RESERVED_ENTRIES);
  localparam logic [CW-1:0] FREE_INIT = CW'(TABLE_ENTRIES - RESERVED_ENTRIES);

  state_t state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              in_range_r, in_range_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     free_cnt_r, free_cnt_nxt;
  logic [CW-1:0]     busy_cnt_r, busy_cnt_nxt;
  // entries at or above fresh_r were never popped from the initial chain
  logic [CW-1:0]     fresh_r, fresh_nxt;
  // reserved entries read as busy until their first release writes the RAM
  logic [1:0]        touched_r, touched_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_FIELD_W-1:0] out_granted_r, out_granted_nxt;
  stat_t             out_status_r, out_status_nxt;

  logic          acc, fin;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [IW-1:0] link_rd;
  logic          busy_rd;
  logic          head_fresh;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] pop_next;
  logic          idx_rsv;
  logic          idx_fresh;
  logic          busy_now;

  ifla_ram #(
    .DEPTH (TABLE_ENTRIES),
    .ADDR_W(IW),
    .DATA_W(EW)
  ) u_ram (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign acc      = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign fin      = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign rd_en   = acc;
  assign rd_addr = in_mode ? IW'(in_release_index) : head_r;

  assign link_rd    = rd_data[IW-1:0];
  assign busy_rd    = rd_data[IW];
  assign head_fresh = (CW'(head_r) == fresh_r);
  assign head_inc   = (head_r == LAST_IDX) ? '0 : head_r + IW'(1);
  assign pop_next   = head_fresh ? head_inc : link_rd;
  assign idx_rsv    = (CW'(idx_r) < RSV_CNT);
  assign idx_fresh  = (CW'(idx_r) >= fresh_r);

  always_comb begin
    if (idx_rsv && !touched_r[idx_r[0]]) begin
      busy_now = 1'b1;
    end else if (idx_fresh) begin
      busy_now = 1'b0;
    end else begin
      busy_now = busy_rd;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    idx_nxt         = idx_r;
    in_range_nxt    = in_range_r;
    head_nxt        = head_r;
    free_cnt_nxt    = free_cnt_r;
    busy_cnt_nxt    = busy_cnt_r;
    fresh_nxt       = fresh_r;
    touched_nxt     = touched_r;
    out_valid_nxt   = out_valid_r;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    wr_en           = 1'b0;
    wr_addr         = idx_r;
    wr_data         = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (acc) begin
      state_nxt    = S_EXEC;
      mode_nxt     = in_mode;
      idx_nxt      = IW'(in_release_index);
      in_range_nxt = (32'(in_release_index) < 32'(TABLE_ENTRIES));
    end

    if (fin) begin
      state_nxt       = S_IDLE;
      out_valid_nxt   = 1'b1;
      out_granted_nxt = '0;
      out_status_nxt  = ST_OK;
      if (!mode_r) begin
        if (free_cnt_r == '0) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_granted_nxt = IDX_FIELD_W'(head_r);
          head_nxt        = pop_next;
          if (head_fresh) begin
            fresh_nxt = fresh_r + CW'(1);
          end
          wr_en        = 1'b1;
          wr_addr      = head_r;
          wr_data      = {1'b1, pop_next};
          free_cnt_nxt = free_cnt_r - CW'(1);
          busy_cnt_nxt = busy_cnt_r + CW'(1);
        end
      end else begin
        if (!in_range_r || !busy_now) begin
          out_status_nxt = ST_BAD;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = idx_r;
          wr_data  = {1'b0, head_r};
          head_nxt = idx_r;
          if (idx_rsv) begin
            touched_nxt[idx_r[0]] = 1'b1;
          end
          free_cnt_nxt = free_cnt_r + CW'(1);
          busy_cnt_nxt = busy_cnt_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= HEAD_INIT;
      free_cnt_r  <= FREE_INIT;
      busy_cnt_r  <= RSV_CNT;
      fresh_r     <= RSV_CNT;
      touched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      busy_cnt_r  <= busy_cnt_nxt;
      fresh_r     <= fresh_nxt;
      touched_r   <= touched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    idx_r         <= idx_nxt;
    in_range_r    <= in_range_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  // counters only move when a new result is loaded, so they track the held beat
  assign out_valid         = out_valid_r;
  assign out_granted_index = out_granted_r;
  assign out_status        = out_status_r;
  assign out_free_total    = CNT_FIELD_W'(free_cnt_r);
  assign out_busy_total    = CNT_FIELD_W'(busy_cnt_r);

endmodule

// ----- rtl/ifla_chk.sv -----
// Port-level checker for the index free-list allocator, bound to the top level.
// Depends on ifla_pkg for field widths and status codes.
module ifla_chk
  import ifla_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [IDX_FIELD_W-1:0] out_granted_index,
  input logic [STAT_W-1:0]      out_status,
  input logic [CNT_FIELD_W-1:0] out_free_total,
  input logic [CNT_FIELD_W-1:0] out_busy_total
);

  localparam logic [CNT_FIELD_W-1:0] TOTAL = CNT_FIELD_W'(TABLE_ENTRIES);

  // every entry is either free or busy
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CNT_FIELD_W'(out_free_total + out_busy_total) == TOTAL))
    else $error("free plus busy totals do not cover the table");

  // a failing beat (empty allocate or bad release) never hands out an index
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_granted_index == '0))
    else $error("nonzero index on a failing beat");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_free_total == '0))
    else $error("empty status with free entries left");

  // one item in flight: the beat after an accept is always stalled
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted back to back");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted_index) &&
      $stable(out_status) && $stable(out_free_total) && $stable(out_busy_total))
    else $error("stalled result beat changed");

endmodule

bind index_free_list_allocator ifla_chk #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_ifla_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_granted_index(out_granted_index),
  .out_status       (out_status),
  .out_free_total   (out_free_total),
  .out_busy_total   (out_busy_total)
);
